/* sv/sdf_pkg.sv */
// Package for the spatial duplicate filter: request and action codes,
// sequencer states, table entry type and default depth. No dependencies.
`default_nettype none
package sdf_pkg;

  localparam int unsigned DefaultDepth = 64;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_SUBMIT = 2'd1,
    REQ_READ   = 2'd2,
    REQ_SPARE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ACT_APPEND  = 3'd0,
    ACT_REPLACE = 3'd1,
    ACT_DISCARD = 3'd2,
    ACT_FULL    = 3'd3,
    ACT_CLEAR   = 3'd4,
    ACT_READ    = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_SHIFT,
    ST_WRITE,
    ST_READ,
    ST_OUT
  } state_e;

  // one table entry: kind, coordinates x/y/z, tolerance
  typedef struct packed {
    logic [15:0] tol;
    logic [15:0] z;
    logic [15:0] y;
    logic [15:0] x;
    logic [7:0]  kind;
  } entry_t;

endpackage
`default_nettype wire

/* sv/sdf_dist.sv */
// Duplicate test unit: registered squared-distance compare of one pair.
// Depends on sdf_pkg for the entry type.
`default_nettype none
module sdf_dist (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sdf_pkg::entry_t a_i,
  input  sdf_pkg::entry_t b_i,
  input  logic [15:0]     tol_i,
  output logic            dup_o
);
  import sdf_pkg::*;

  logic [16:0] dx, dy, dz;
  logic [16:0] adx, ady, adz;
  logic [33:0] sx_q, sy_q, sz_q;
  logic [31:0] t2_q;
  logic        kind_eq_q, exact_q, zero_q;
  logic [35:0] sum;

  // stage 1: differences, squares
  assign dx = {a_i.x[15], a_i.x} - {b_i.x[15], b_i.x};
  assign dy = {a_i.y[15], a_i.y} - {b_i.y[15], b_i.y};
  assign dz = {a_i.z[15], a_i.z} - {b_i.z[15], b_i.z};
  assign adx = dx[16] ? (~dx + 17'd1) : dx;
  assign ady = dy[16] ? (~dy + 17'd1) : dy;
  assign adz = dz[16] ? (~dz + 17'd1) : dz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_eq_q <= 1'b0;
    end else begin
      kind_eq_q <= (a_i.kind == b_i.kind);
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q    <= adx * adx;
    sy_q    <= ady * ady;
    sz_q    <= adz * adz;
    t2_q    <= tol_i * tol_i;
    exact_q <= (a_i.x == b_i.x) && (a_i.y == b_i.y) && (a_i.z == b_i.z);
    zero_q  <= (tol_i == 16'd0);
  end

  // stage 2: sum and compare
  assign sum = {2'b00, sx_q} + {2'b00, sy_q} + {2'b00, sz_q};
  assign dup_o = kind_eq_q && (zero_q ? exact_q : (sum <= {4'd0, t2_q}));

endmodule
`default_nettype wire

/* sv/spatial_duplicate_filter.sv */
// Spatial duplicate filter top level: table memory, scan sequencer, ports.
// Depends on sdf_pkg and sdf_dist.
`default_nettype none
// A submit scans the table one entry per cycle through one registered
// distance unit (entry read, then the registered squares, then compare).
// A match at slot m ends the scan; a replace then moves one entry per
// cycle. One request is handled at a time; s_axis_tready is high only
// while the sequencer idles and no result word waits, so the next word is
// taken in the cycle after the result is taken. The result word is held
// in an output register until taken. The table needs no clearing pass
// after reset.
module spatial_duplicate_filter #(
  parameter int unsigned TABLE_DEPTH = sdf_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[1:0], feature_kind[9:2], coord_x[25:10], coord_y[41:26],
  // coord_z[57:42], feature_tolerance[73:58], read_slot[79:74]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // action[2:0], match_slot[8:3], entry_count[15:9], read_valid[16],
  // out_kind[24:17], out_x[40:25], out_y[56:41], out_z[72:57],
  // out_tolerance[88:73], zeros up to 95
  output logic [95:0] m_axis_tdata
);
  import sdf_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  entry_t      mem [TABLE_DEPTH];
  entry_t      rd_q, new_q, wr_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic        wr_en;

  state_e      st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d, m_q, m_d;
  logic [1:0]  req_q;
  logic [5:0]  slot_q;
  logic [15:0] dtol_q;
  logic        cmp_v_q, cmp_v_d;
  logic        dup;
  logic        res_v_q;
  logic [95:0] res_q, res_d;
  logic        res_ld;
  logic        hit_q;
  logic [2:0]  act;
  logic          cmp_v1_q;
  logic [CW-1:0] idx1_q, idx2_q;
  logic          wr_full_q;
  logic          disc_q;

  // config register, always ready
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dtol_q <= '0;
    end else if (cfg_valid_i) begin
      dtol_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = (st_q == ST_IDLE) && !res_v_q;

  // latch request
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q      <= s_axis_tdata[1:0];
      new_q.kind <= s_axis_tdata[9:2];
      new_q.x    <= s_axis_tdata[25:10];
      new_q.y    <= s_axis_tdata[41:26];
      new_q.z    <= s_axis_tdata[57:42];
      new_q.tol  <= s_axis_tdata[73:58];
      slot_q     <= s_axis_tdata[79:74];
    end
  end

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  sdf_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (new_q),
    .b_i    (rd_q),
    .tol_i  (dtol_q),
    .dup_o  (dup)
  );

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
        unique case (req_e'(s_axis_tdata[1:0]))
          REQ_CLEAR:  st_d = ST_OUT;
          REQ_SUBMIT: st_d = ST_SCAN;
          default:    st_d = ST_READ;
        endcase
      end
      ST_SCAN: begin
        if (cmp_v_q && dup) begin
          st_d = ST_CHECK;
        end else if (idx_q >= cnt_q && !cmp_v1_q) begin
          st_d = ST_WRITE;
        end
      end
      ST_CHECK: st_d = (new_q.tol <= rd_q.tol) ? ST_OUT : ST_SHIFT;
      ST_SHIFT: if (idx_q + CW'(1) >= cnt_q) begin
        st_d = ST_WRITE;
      end
      ST_WRITE: st_d = ST_OUT;
      ST_READ:  st_d = ST_OUT;
      ST_OUT:   st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    idx_d   = idx_q;
    m_d     = m_q;
    cnt_d   = cnt_q;
    cmp_v_d = 1'b0;
    rd_addr = idx_q[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_q[AW-1:0];
    wr_data = rd_q;
    unique case (st_q)
      ST_IDLE: begin
        idx_d = '0;
        if (s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == REQ_CLEAR) begin
          cnt_d = '0;
        end
      end
      ST_SCAN: begin
        // entry idx read this cycle; its compare follows through rd_q and the distance-unit registers
        cmp_v_d = 1'b0;
        if (cmp_v_q && dup) begin
          m_d     = idx2_q;
          idx_d   = idx2_q + CW'(1);
          rd_addr = idx2_q[AW-1:0];
        end else if (idx_q < cnt_q) begin
          idx_d = idx_q + CW'(1);
          cmp_v_d = 1'b1;
        end
      end
      ST_CHECK: begin
        rd_addr = idx_q[AW-1:0];
      end
      ST_SHIFT: begin
        // rd_q holds entry idx; write it to idx-1
        if (idx_q < cnt_q) begin
          wr_en   = 1'b1;
          wr_addr = AW'(idx_q - CW'(1));
          wr_data = rd_q;
        end
        idx_d   = idx_q + CW'(1);
        rd_addr = AW'(idx_q + CW'(1));
      end
      ST_WRITE: begin
        wr_data = new_q;
        if (hit_q) begin
          wr_en   = 1'b1;
          wr_addr = AW'(cnt_q - CW'(1));
        end else if (cnt_q < CW'(TABLE_DEPTH)) begin
          wr_en   = 1'b1;
          wr_addr = cnt_q[AW-1:0];
          cnt_d   = cnt_q + CW'(1);
        end
      end
      ST_READ: rd_addr = AW'(slot_q);
      default: ;
    endcase
  end

  // scan pipeline: slot index and valid bit follow the compare through idx1_q/cmp_v1_q, then idx2_q/cmp_v_q
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      m_q      <= '0;
      cmp_v1_q <= 1'b0;
      cmp_v_q  <= 1'b0;
      hit_q    <= 1'b0;
      idx1_q   <= '0;
      idx2_q   <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      if (st_q == ST_SCAN && !(cmp_v_q && dup)) begin
        cmp_v1_q <= cmp_v_d;
        cmp_v_q  <= cmp_v1_q;
        idx1_q   <= idx_q;
        idx2_q   <= idx1_q;
      end else begin
        cmp_v1_q <= 1'b0;
        cmp_v_q  <= 1'b0;
      end
      if (st_q == ST_IDLE) begin
        hit_q <= 1'b0;
      end else if (st_q == ST_SCAN && cmp_v_q && dup) begin
        hit_q <= 1'b1;
      end
      m_q <= m_d;
    end
  end

  // result word
  always_comb begin
    act = ACT_READ;
    res_d = '0;
    res_ld = (st_q == ST_OUT);
    if (req_q == REQ_CLEAR) begin
      act = ACT_CLEAR;
    end else if (req_q == REQ_SUBMIT) begin
      if (hit_q) begin
        act = disc_q ? ACT_DISCARD : ACT_REPLACE;
      end else begin
        act = wr_full_q ? ACT_FULL : ACT_APPEND;
      end
    end
    res_d[2:0]  = act;
    res_d[8:3]  = (req_q == REQ_SUBMIT && hit_q) ? 6'(m_q) : 6'd0;
    res_d[15:9] = 7'(cnt_q);
    if ((req_q == REQ_READ || req_q == REQ_SPARE)
        && CW'(slot_q) < cnt_q && 32'(slot_q) < TABLE_DEPTH) begin
      res_d[16]    = 1'b1;
      res_d[24:17] = rd_q.kind;
      res_d[40:25] = rd_q.x;
      res_d[56:41] = rd_q.y;
      res_d[72:57] = rd_q.z;
      res_d[88:73] = rd_q.tol;
    end
  end

  // full flag seen at append time; discard decision kept from the check
  always_ff @(posedge clk_i) begin
    if (st_q == ST_WRITE) begin
      wr_full_q <= !hit_q && (cnt_q >= CW'(TABLE_DEPTH));
    end
    if (st_q == ST_CHECK) begin
      disc_q <= (new_q.tol <= rd_q.tol);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (res_ld) begin
      res_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      res_v_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (res_ld) begin
      res_q <= res_d;
    end
  end
  assign m_axis_tvalid = res_v_q;
  assign m_axis_tdata  = res_q;

  // assertions
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH)) else $error("count beyond depth");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v_q && !m_axis_tready) |=> res_v_q) else $error("result lost");

endmodule
`default_nettype wire

/* dv/spatial_duplicate_filter_tb.sv */
// Testbench for spatial_duplicate_filter: drives clear/submit/read words,
// predicts each result word with a behavioral table model. Depends on sdf_pkg.
`timescale 1ns / 1ps
module spatial_duplicate_filter_tb;
  import sdf_pkg::*;

  localparam int Depth = 64;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic [5:0]  slot;
    logic [15:0] tol;
    logic [15:0] z;
    logic [15:0] y;
    logic [15:0] x;
    logic [7:0]  kind;
    logic [1:0]  req;
  } req_word_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic [15:0] tol;
    logic [15:0] z;
    logic [15:0] y;
    logic [15:0] x;
    logic [7:0]  kind;
    logic        rvalid;
    logic [6:0]  count;
    logic [5:0]  mslot;
    logic [2:0]  action;
  } res_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;

  spatial_duplicate_filter dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // predictor state
  entry_t    tbl [Depth];
  int        tbl_count;
  logic [15:0] radius;

  req_word_t pending_reqs[$];
  res_word_t expected_results[$];
  int        errors;
  int        idle_pct;
  bit        hold_send;
  int        quiet_cycles;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic bit near(entry_t e, req_word_t r);
    longint dx, dy, dz, d2, t;
    if (radius == 0) return {e.x, e.y, e.z} == {r.x, r.y, r.z};
    dx = longint'($signed(r.x)) - longint'($signed(e.x));
    dy = longint'($signed(r.y)) - longint'($signed(e.y));
    dz = longint'($signed(r.z)) - longint'($signed(e.z));
    d2 = dx * dx + dy * dy + dz * dz;
    t = longint'(radius);
    return d2 <= t * t;
  endfunction

  // table behavior for one accepted request word
  function automatic res_word_t filter_predict(req_word_t r);
    res_word_t o;
    int m;
    entry_t n;
    o = '0;
    m = -1;
    case (req_e'(r.req))
      REQ_CLEAR: begin
        tbl_count = 0;
        o.action = ACT_CLEAR;
      end
      REQ_SUBMIT: begin
        n.kind = r.kind; n.x = r.x; n.y = r.y; n.z = r.z; n.tol = r.tol;
        for (int i = 0; i < tbl_count; i++)
          if (m < 0 && tbl[i].kind == r.kind && near(tbl[i], r)) m = i;
        if (m >= 0) begin
          o.mslot = m[5:0];
          if (r.tol <= tbl[m].tol) o.action = ACT_DISCARD;
          else begin
            for (int i = m; i + 1 < tbl_count; i++) tbl[i] = tbl[i + 1];
            tbl[tbl_count - 1] = n;
            o.action = ACT_REPLACE;
          end
        end else if (tbl_count >= Depth) o.action = ACT_FULL;
        else begin
          tbl[tbl_count] = n;
          tbl_count++;
          o.action = ACT_APPEND;
        end
      end
      default: begin
        o.action = ACT_READ;
        if (r.slot < tbl_count) begin
          o.rvalid = 1'b1;
          o.kind = tbl[r.slot].kind; o.x = tbl[r.slot].x; o.y = tbl[r.slot].y;
          o.z = tbl[r.slot].z; o.tol = tbl[r.slot].tol;
        end
      end
    endcase
    o.count = tbl_count[6:0];
    return o;
  endfunction

  // driver: one word at a time from the pending queue
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(filter_predict(req_word_t'(s_axis_tdata)));
        void'(pending_reqs.pop_front());
      end
      if ((!s_axis_tvalid || s_axis_tready) ) begin
        if (pending_reqs.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0) &&
            !hold_send && $urandom_range(99) >= idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_reqs[0];
        end else s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: check result words, random back-pressure, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        res_word_t got, want;
        got = m_axis_tdata;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", 32'(got.action), 0);
        end else begin
          want = expected_results.pop_front();
          if (got.action !== want.action)
            report_mismatch("action", 32'(got.action), 32'(want.action));
          if (got.mslot !== want.mslot)
            report_mismatch("match_slot", 32'(got.mslot), 32'(want.mslot));
          if (got.count !== want.count)
            report_mismatch("entry_count", 32'(got.count), 32'(want.count));
          if (got.rvalid !== want.rvalid)
            report_mismatch("read_valid", 32'(got.rvalid), 32'(want.rvalid));
          if (got.kind !== want.kind)
            report_mismatch("out_kind", 32'(got.kind), 32'(want.kind));
          if (got.x !== want.x) report_mismatch("out_x", 32'(got.x), 32'(want.x));
          if (got.y !== want.y) report_mismatch("out_y", 32'(got.y), 32'(want.y));
          if (got.z !== want.z) report_mismatch("out_z", 32'(got.z), 32'(want.z));
          if (got.tol !== want.tol)
            report_mismatch("out_tolerance", 32'(got.tol), 32'(want.tol));
          if (got.pad !== '0) report_mismatch("padding", 32'(got.pad), 0);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
      if (quiet_cycles >= WatchLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic req_word_t make_req(logic [1:0] req, logic [7:0] kind,
                                         logic [15:0] x, logic [15:0] y,
                                         logic [15:0] z, logic [15:0] tol,
                                         logic [5:0] slot);
    req_word_t r;
    r.req = req; r.kind = kind; r.x = x; r.y = y; r.z = z; r.tol = tol; r.slot = slot;
    return r;
  endfunction

  // random word; submits cluster near a few anchors so matches happen
  function automatic req_word_t rand_req();
    int sel;
    logic [15:0] bx, by, bz;
    sel = $urandom_range(99);
    bx = 16'($urandom_range(3) * 16'h0100); by = 16'($urandom_range(3) * 16'h4000);
    bz = 16'($urandom_range(1) ? 16'h8000 : 16'h7F00);
    if (sel < 2) return make_req(REQ_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom), 6'($urandom));
    if (sel < 20) return make_req(sel < 4 ? REQ_SPARE : REQ_READ, 8'($urandom),
                                  16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 6'($urandom));
    if (sel < 30) return make_req(REQ_SUBMIT, 8'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom), 6'($urandom));
    return make_req(REQ_SUBMIT, 8'($urandom_range(2)), bx + 16'($urandom_range(40)),
                    by + 16'($urandom_range(40)), bz + 16'($urandom_range(40)),
                    16'($urandom_range(64)), 6'($urandom));
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_results.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    radius = val;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    errors = 0; tbl_count = 0; radius = '0; idle_pct = 26; hold_send = 0;
    quiet_cycles = 0;
    for (int i = 0; i < Depth; i++) tbl[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: exact equality mode, extremes, replace/discard, reads, spare code
    pending_reqs.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_SUBMIT, 8'hFF, 16'h8000, 16'h7FFF, 16'hFFFF,
                                    16'h0010, 6'h3F));
    pending_reqs.push_back(make_req(REQ_SUBMIT, 8'h00, 16'h7FFF, 16'h8000, 16'h0000,
                                    16'hFFFF, 0));
    pending_reqs.push_back(make_req(REQ_SUBMIT, 8'hFF, 16'h8000, 16'h7FFF, 16'hFFFF,
                                    16'h0010, 0));
    pending_reqs.push_back(make_req(REQ_SUBMIT, 8'hFF, 16'h8000, 16'h7FFF, 16'hFFFF,
                                    16'h0011, 0));
    pending_reqs.push_back(make_req(REQ_SUBMIT, 8'hFE, 16'h8000, 16'h7FFF, 16'hFFFF,
                                    16'h0000, 0));
    pending_reqs.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 6'd1));
    pending_reqs.push_back(make_req(REQ_SPARE, 0, 0, 0, 0, 0, 6'd2));
    pending_reqs.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 6'h3F));
    pending_reqs.push_back(make_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
    // fill the table, then overflow it
    for (int i = 0; i < Depth + 2; i++)
      pending_reqs.push_back(make_req(REQ_SUBMIT, 8'h5A, 16'(i), 0, 0, 16'h0100, 0));
    pending_reqs.push_back(make_req(REQ_SUBMIT, 8'h5A, 16'd3, 0, 0, 16'h0200, 0));
    pending_reqs.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 6'h3F));
    hold_send = 1;
    idle_pct = 0;
    hold_send = 0;
    wait_drained();

    // widest radius against far-apart points
    write_radius(16'hFFFF);
    pending_reqs.push_back(make_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_SUBMIT, 1, 16'h8000, 16'h8000, 16'h8000, 1, 0));
    pending_reqs.push_back(make_req(REQ_SUBMIT, 1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 2, 0));
    pending_reqs.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 0));
    wait_drained();

    // random phases with several radius settings
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: write_radius(16'h0001);
        1: write_radius(16'h0020);
        2: write_radius(16'h0000);
        3: write_radius(16'($urandom));
        default: write_radius(16'h0040);
      endcase
      idle_pct = (p == 2) ? 0 : 26;
      for (int i = 0; i < 100; i++) pending_reqs.push_back(rand_req());
      if (p == 1) begin
        // sender pause until all results are back
        while (pending_reqs.size() > 50) @(posedge clk_i);
        hold_send = 1;
        while (expected_results.size() != 0 || s_axis_tvalid) @(posedge clk_i);
        hold_send = 0;
      end
      wait_drained();
    end

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

/* sim.f */
sv/sdf_pkg.sv
sv/sdf_dist.sv
sv/spatial_duplicate_filter.sv
dv/spatial_duplicate_filter_tb.sv
